/* rtl/rti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, register indexes and operand tables for the ray/triangle test.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MIN_FRAC   = 16;
    localparam int MIN_BITS   = 16;
    localparam int DIST_W     = 31;
    localparam int ADDR_W     = 3;
    localparam int NUM_VERT   = 9;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PAIR_W  = 2 * DIFF_W;
    localparam int MINOR_W = PAIR_W + 1;
    localparam int SPLIT   = DIFF_W + 1;
    localparam int HI_W    = MINOR_W - SPLIT;
    localparam int LO_W    = DIFF_W + SPLIT + 1;
    localparam int HIP_W   = DIFF_W + HI_W;
    localparam int PROD_W  = DIFF_W + MINOR_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int CH_W    = (SUM_W + 2) / 3;
    localparam int CHP_W   = CH_W + MIN_BITS;
    localparam int CMP_W   = SUM_W + MIN_BITS + 1;
    localparam int REM_W   = SUM_W + DIST_W;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_ORG_X = 3'd0;
    localparam logic [ADDR_W-1:0] REG_ORG_Y = 3'd1;
    localparam logic [ADDR_W-1:0] REG_ORG_Z = 3'd2;
    localparam logic [ADDR_W-1:0] REG_DIR_X = 3'd3;
    localparam logic [ADDR_W-1:0] REG_DIR_Y = 3'd4;
    localparam logic [ADDR_W-1:0] REG_DIR_Z = 3'd5;
    localparam logic [ADDR_W-1:0] REG_MIN_D = 3'd6;

    // edge / offset vector slots
    localparam int IX_EA = 0;
    localparam int IX_EB = 1;
    localparam int IX_FA = 2;
    localparam int IX_FB = 3;
    localparam int IX_GA = 4;
    localparam int IX_GB = 5;
    localparam int IX_OX = 6;
    localparam int IX_OY = 7;
    localparam int IX_OZ = 8;
    localparam int IX_DX = 9;
    localparam int IX_DY = 10;
    localparam int IX_DZ = 11;

    // 2x2 minor products: minor k = PA[2k]*PB[2k] - PA[2k+1]*PB[2k+1]
    localparam int PA [12] = '{IX_FB, IX_DY, IX_OY, IX_DY, IX_FB, IX_OY,
                              IX_DY, IX_FA, IX_FA, IX_FB, IX_FA, IX_OY};
    localparam int PB [12] = '{IX_DZ, IX_GB, IX_DZ, IX_OZ, IX_OZ, IX_GB,
                              IX_GA, IX_DZ, IX_GB, IX_GA, IX_OZ, IX_GA};

    // 3x3 terms: left operand slot (0 ea, 1 eb, 2 dx, 3 ox), minor index
    localparam int TE [12] = '{0, 1, 2, 3, 1, 2, 0, 3, 2, 0, 1, 3};
    localparam int TM [12] = '{0, 3, 4, 0, 1, 2, 1, 3, 5, 2, 5, 4};

endpackage

/* rtl/ray_triangle_intersect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Ray / triangle hit test by Cramer's rule, signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   The ray (origin, direction) and min_distance are loaded through the
//   cfg_we / cfg_addr / cfg_wdata write port while the pipe is empty.
//   Each s_ beat carries one triangle: nine 32-bit vertex coordinates.
//   Each m_ beat returns is_hit and the saturated unsigned Q15.16 distance.
//   The pipe has 9 arithmetic stages (differences, 2x2 minors, split
//   33x67 products, sums, sign fix, range checks) followed by 31
//   restoring-divide stages, one quotient bit each.
//   Throughput is one beat per cycle while the output is not stalled.
//   The whole pipe advances on one enable; when m_tvalid is high and
//   m_tready low, every stage holds and s_tready drops.
//   Reset (aresetn low, synchronous) empties the pipe and loads the
//   register reset values (min_distance 66, others zero).
// ----------------------------------------------------------------------------
module ray_triangle_intersect
    import rti_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ADDR_W-1:0]              cfg_addr,
    input  logic [COORD_BITS-1:0]          cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [NUM_VERT*COORD_BITS-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // is_hit, hit_distance
    output logic [DIST_W:0]                m_tdata
);

    localparam int NDIV = DIST_W;
    localparam int NV   = 9 + NDIV;

    logic ce;
    logic [NV-1:0] v_reg;

    logic signed [COORD_BITS-1:0] org_reg [3];
    logic signed [COORD_BITS-1:0] dir_reg [3];
    logic [MIN_BITS-1:0]          mind_reg;

    logic signed [COORD_BITS-1:0] vin [NUM_VERT];

    logic signed [DIFF_W-1:0]  d1_reg [12];
    logic signed [PAIR_W-1:0]  pr2_reg [12];
    logic signed [DIFF_W-1:0]  e2_reg [4];
    logic signed [MINOR_W-1:0] m3_reg [6];
    logic signed [DIFF_W-1:0]  e3_reg [4];
    logic signed [LO_W-1:0]    lo4_reg [12];
    logic signed [HIP_W-1:0]   hi4_reg [12];
    logic signed [PROD_W-1:0]  p5_reg [12];
    logic signed [SUM_W-1:0]   s6_reg [4];
    logic signed [SUM_W-1:0]   s7_reg [4];
    logic                      zero7_reg;
    logic [CHP_W-1:0]          md8_reg [3];
    logic signed [SUM_W-1:0]   n3_8_reg;
    logic [SUM_W-1:0]          den8_reg;
    logic                      miss8_reg;

    logic [REM_W-1:0]  rem_reg [NDIV+1];
    logic [SUM_W-1:0]  den_reg [NDIV+1];
    logic [NDIV-1:0]   q_reg [NDIV+1];
    logic              hit_reg [NDIV+1];
    logic              sat_reg [NDIV+1];

    logic signed [SUM_W:0]   n12_sum;
    logic [3*CH_W-1:0]       den_pad;
    logic [CMP_W-1:0]        md_sum;
    logic signed [CMP_W-1:0] n3_sh;
    logic [REM_W-1:0]        num9;
    logic [REM_W-1:0]        den_top;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;
    assign m_tvalid = v_reg[NV-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg  <= '{default: '0};
            dir_reg  <= '{default: '0};
            mind_reg <= MIN_BITS'(66);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ORG_X: org_reg[0] <= cfg_wdata;
                REG_ORG_Y: org_reg[1] <= cfg_wdata;
                REG_ORG_Z: org_reg[2] <= cfg_wdata;
                REG_DIR_X: dir_reg[0] <= cfg_wdata;
                REG_DIR_Y: dir_reg[1] <= cfg_wdata;
                REG_DIR_Z: dir_reg[2] <= cfg_wdata;
                REG_MIN_D: mind_reg   <= cfg_wdata[MIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[NV-2:0], s_tvalid};
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_VERT; i++) begin
            vin[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
        end
    end

    // stage 1: edge and offset vectors
    always_ff @(posedge aclk) begin
        if (ce) begin
            d1_reg[IX_EA] <= DIFF_W'(vin[0]) - DIFF_W'(vin[3]);
            d1_reg[IX_EB] <= DIFF_W'(vin[0]) - DIFF_W'(vin[6]);
            d1_reg[IX_FA] <= DIFF_W'(vin[1]) - DIFF_W'(vin[4]);
            d1_reg[IX_FB] <= DIFF_W'(vin[1]) - DIFF_W'(vin[7]);
            d1_reg[IX_GA] <= DIFF_W'(vin[2]) - DIFF_W'(vin[5]);
            d1_reg[IX_GB] <= DIFF_W'(vin[2]) - DIFF_W'(vin[8]);
            d1_reg[IX_OX] <= DIFF_W'(vin[0]) - DIFF_W'(org_reg[0]);
            d1_reg[IX_OY] <= DIFF_W'(vin[1]) - DIFF_W'(org_reg[1]);
            d1_reg[IX_OZ] <= DIFF_W'(vin[2]) - DIFF_W'(org_reg[2]);
            d1_reg[IX_DX] <= DIFF_W'(dir_reg[0]);
            d1_reg[IX_DY] <= DIFF_W'(dir_reg[1]);
            d1_reg[IX_DZ] <= DIFF_W'(dir_reg[2]);
        end
    end

    // stage 2: minor products; stage 3: minors
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 12; i++) begin
                pr2_reg[i] <= d1_reg[PA[i]] * d1_reg[PB[i]];
            end
            e2_reg[0] <= d1_reg[IX_EA];
            e2_reg[1] <= d1_reg[IX_EB];
            e2_reg[2] <= d1_reg[IX_DX];
            e2_reg[3] <= d1_reg[IX_OX];
            for (int k = 0; k < 6; k++) begin
                m3_reg[k] <= MINOR_W'(pr2_reg[2*k]) - MINOR_W'(pr2_reg[2*k+1]);
            end
            e3_reg <= e2_reg;
        end
    end

    // stage 4: 33x67 terms as two partial products; stage 5: recombine
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 12; i++) begin
                lo4_reg[i] <= e3_reg[TE[i]] * $signed({1'b0, m3_reg[TM[i]][SPLIT-1:0]});
                hi4_reg[i] <= e3_reg[TE[i]] * $signed(m3_reg[TM[i]][MINOR_W-1:SPLIT]);
            end
            for (int i = 0; i < 12; i++) begin
                p5_reg[i] <= (PROD_W'(hi4_reg[i]) <<< SPLIT) + PROD_W'(lo4_reg[i]);
            end
        end
    end

    // stage 6: determinants; stage 7: make denominator positive
    always_ff @(posedge aclk) begin
        if (ce) begin
            s6_reg[0] <= SUM_W'(p5_reg[0]) + SUM_W'(p5_reg[1]) + SUM_W'(p5_reg[2]);
            s6_reg[1] <= SUM_W'(p5_reg[3]) - SUM_W'(p5_reg[4]) - SUM_W'(p5_reg[5]);
            s6_reg[2] <= SUM_W'(p5_reg[6]) + SUM_W'(p5_reg[7]) + SUM_W'(p5_reg[8]);
            s6_reg[3] <= SUM_W'(p5_reg[9]) - SUM_W'(p5_reg[10]) + SUM_W'(p5_reg[11]);
            zero7_reg <= (s6_reg[0] == '0);
            for (int i = 0; i < 4; i++) begin
                s7_reg[i] <= s6_reg[0][SUM_W-1] ? -s6_reg[i] : s6_reg[i];
            end
        end
    end

    // stage 8: barycentric checks, min_distance * den partial products
    assign n12_sum = (SUM_W+1)'(s7_reg[1]) + (SUM_W+1)'(s7_reg[2]);
    assign den_pad = (3*CH_W)'(unsigned'(s7_reg[0]));

    always_ff @(posedge aclk) begin
        if (ce) begin
            miss8_reg <= zero7_reg || s7_reg[1][SUM_W-1] || s7_reg[2][SUM_W-1]
                         || ((SUM_W+1)'(s7_reg[0]) < n12_sum);
            for (int c = 0; c < 3; c++) begin
                md8_reg[c] <= CHP_W'(mind_reg) * CHP_W'(den_pad[c*CH_W +: CH_W]);
            end
            n3_8_reg <= s7_reg[3];
            den8_reg <= unsigned'(s7_reg[0]);
        end
    end

    // stage 9: distance check, saturation, divider setup
    assign md_sum = CMP_W'(md8_reg[0]) + (CMP_W'(md8_reg[1]) << CH_W)
                  + (CMP_W'(md8_reg[2]) << (2*CH_W));
    assign n3_sh   = CMP_W'(n3_8_reg) <<< MIN_FRAC;
    assign num9    = REM_W'(unsigned'(n3_8_reg)) << FRAC_BITS;
    assign den_top = REM_W'(den8_reg) << DIST_W;

    always_ff @(posedge aclk) begin
        if (ce) begin
            hit_reg[0] <= !miss8_reg && !(n3_sh < $signed({1'b0, md_sum[CMP_W-2:0]}));
            sat_reg[0] <= (num9 >= den_top);
            rem_reg[0] <= num9;
            den_reg[0] <= den8_reg;
            q_reg[0]   <= '0;
        end
    end

    // restoring divide, one quotient bit per stage, MSB first
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        localparam int B = NDIV - 1 - k;
        logic [REM_W-1:0] sub;
        assign sub = REM_W'(den_reg[k]) << B;
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (rem_reg[k] >= sub) begin
                    rem_reg[k+1]  <= rem_reg[k] - sub;
                    q_reg[k+1]    <= q_reg[k] | (NDIV'(1) << B);
                end else begin
                    rem_reg[k+1]  <= rem_reg[k];
                    q_reg[k+1]    <= q_reg[k];
                end
                den_reg[k+1] <= den_reg[k];
                hit_reg[k+1] <= hit_reg[k];
                sat_reg[k+1] <= sat_reg[k];
            end
        end
    end

    assign m_tdata = {(!hit_reg[NDIV]) ? '0 : (sat_reg[NDIV] ? DIST_MAX : q_reg[NDIV]),
                      hit_reg[NDIV]};

endmodule

/* rtl/rti_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_checker
// Port-level checks for ray_triangle_intersect.
// ----------------------------------------------------------------------------
module rti_checker
    import rti_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DIST_W:0]   m_tdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[DIST_W:1] == '0)
        else $error("miss with nonzero distance");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* dv/ray_triangle_intersect_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_tb
// Self-checking bench for the ray/triangle hit test. Triangles are streamed
// under random idling and a long output hold-off. Each accepted beat is
// predicted with exact wide-integer determinants, and each result beat is
// checked in order against the prediction.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_tb;
    import rti_pkg::*;

    typedef logic signed [255:0] wide_t;
    typedef logic [NUM_VERT*COORD_BITS-1:0] tri_t;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 60;
    localparam logic [ADDR_W-1:0] REG_UNUSED = 3'd7;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [ADDR_W-1:0]     cfg_addr;
    logic [COORD_BITS-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    tri_t                  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DIST_W:0]       m_tdata;

    ray_triangle_intersect dut (.*);

    logic signed [COORD_BITS-1:0] org [3];
    logic signed [COORD_BITS-1:0] dir [3];
    logic [MIN_BITS-1:0]          min_d;

    tri_t            tri_pending [$];
    logic [DIST_W:0] hit_expected [$];
    int              in_gap;
    int              out_hold;
    bit              no_idle;
    int              n_fail;
    int              quiet;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [DIST_W:0] predict_hit(tri_t t);
        wide_t v [9];
        wide_t ea, eb, fa, fb, ga, gb, ox, oy, oz, dx, dy, dz;
        wide_t m1, m2, m3, m4, m5, m6, den, n1, n2, n3, num;
        logic [DIST_W-1:0] q;
        for (int i = 0; i < 9; i++) v[i] = $signed(t[i*COORD_BITS +: COORD_BITS]);
        ea = v[0] - v[3]; eb = v[0] - v[6]; ox = v[0] - wide_t'(org[0]);
        fa = v[1] - v[4]; fb = v[1] - v[7]; oy = v[1] - wide_t'(org[1]);
        ga = v[2] - v[5]; gb = v[2] - v[8]; oz = v[2] - wide_t'(org[2]);
        dx = dir[0]; dy = dir[1]; dz = dir[2];
        m1 = fb * dz - dy * gb;
        m2 = oy * dz - dy * oz;
        m3 = fb * oz - oy * gb;
        m4 = dy * ga - fa * dz;
        m5 = fa * gb - fb * ga;
        m6 = fa * oz - oy * ga;
        den = ea * m1 + eb * m4 + dx * m5;
        n1  = ox * m1 - eb * m2 - dx * m3;
        n2  = ea * m2 + ox * m4 + dx * m6;
        n3  = ea * m3 - eb * m6 + ox * m5;
        if (den == 0) return '0;
        if (den < 0) begin
            den = -den; n1 = -n1; n2 = -n2; n3 = -n3;
        end
        if (n1 < 0 || n2 < 0) return '0;
        if (den < n1 + n2) return '0;
        if ((n3 <<< MIN_FRAC) < wide_t'(min_d) * den) return '0;
        num = n3 <<< FRAC_BITS;
        if (num >= (den <<< 31)) q = DIST_MAX;
        else q = DIST_W'(num / den);
        return {q, 1'b1};
    endfunction

    task automatic report_mismatch(string what, logic [DIST_W:0] got, logic [DIST_W:0] want);
        $display("ERROR %0t %s: got hit=%0d dist=%0h, want hit=%0d dist=%0h",
                 $realtime, what, got[0], got[DIST_W:1], want[0], want[DIST_W:1]);
        n_fail++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stimulus side
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (in_gap > 0) begin
            s_tvalid <= 1'b0;
            in_gap--;
        end else if (tri_pending.size() > 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= tri_pending[0];
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (out_hold > 0) begin
            m_tready <= 1'b0;
            out_hold--;
        end else begin
            out_hold = pick_gap();
            m_tready <= (out_hold == 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            quiet++;
            if (s_tvalid && s_tready) begin
                hit_expected.push_back(predict_hit(tri_pending.pop_front()));
                in_gap = pick_gap();
                quiet = 0;
            end
            if (m_tvalid && m_tready) begin
                quiet = 0;
                if (hit_expected.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, '0);
                end else begin
                    logic [DIST_W:0] want;
                    want = hit_expected.pop_front();
                    if (m_tdata[0] !== want[0])
                        report_mismatch("is_hit", m_tdata, want);
                    else if (m_tdata[DIST_W:1] !== want[DIST_W:1])
                        report_mismatch("hit_distance", m_tdata, want);
                end
            end
            if (quiet >= WATCHDOG) begin
                $display("ray_triangle_intersect: mismatch");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [ADDR_W-1:0] idx, logic [COORD_BITS-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ORG_X: org[0] = val;
            REG_ORG_Y: org[1] = val;
            REG_ORG_Z: org[2] = val;
            REG_DIR_X: dir[0] = val;
            REG_DIR_Y: dir[1] = val;
            REG_DIR_Z: dir[2] = val;
            REG_MIN_D: min_d  = val[MIN_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz, int md);
        cfg_write(REG_ORG_X, ox);
        cfg_write(REG_ORG_Y, oy);
        cfg_write(REG_ORG_Z, oz);
        cfg_write(REG_DIR_X, dx);
        cfg_write(REG_DIR_Y, dy);
        cfg_write(REG_DIR_Z, dz);
        cfg_write(REG_MIN_D, md);
    endtask

    task automatic push_tri(int ax, int ay, int az, int bx, int by, int bz,
                            int cx, int cy, int cz);
        tri_pending.push_back({cz, cy, cx, bz, by, bx, az, ay, az == az ? ax : ax});
    endtask

    task automatic wait_idle();
        while (tri_pending.size() > 0 || hit_expected.size() > 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic int srand(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // triangle built around a point on the ray, barycentrics in eighths
    task automatic push_aimed();
        longint px, py, pz, e1x, e1y, e1z, e2x, e2y, e2z;
        int kn, bn, gn;
        kn = $urandom_range(0, 64);
        bn = $urandom_range(0, 9);
        gn = $urandom_range(0, 9 - bn);
        px = org[0] + ((longint'(dir[0]) * kn) >>> 4);
        py = org[1] + ((longint'(dir[1]) * kn) >>> 4);
        pz = org[2] + ((longint'(dir[2]) * kn) >>> 4);
        e1x = 8 * srand(1 << 17); e1y = 8 * srand(1 << 17); e1z = 8 * srand(1 << 17);
        e2x = 8 * srand(1 << 17); e2y = 8 * srand(1 << 17); e2z = 8 * srand(1 << 17);
        px -= (bn * e1x + gn * e2x) / 8;
        py -= (bn * e1y + gn * e2y) / 8;
        pz -= (bn * e1z + gn * e2z) / 8;
        push_tri(int'(px), int'(py), int'(pz),
                 int'(px + e1x), int'(py + e1y), int'(pz + e1z),
                 int'(px + e2x), int'(py + e2y), int'(pz + e2z));
    endtask

    task automatic push_noise();
        push_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
    endtask

    initial begin
        int z;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        in_gap    = 0;
        out_hold  = 0;
        no_idle   = 1'b0;
        n_fail    = 0;
        quiet     = 0;
        org = '{0, 0, 0};
        dir = '{0, 0, 0};
        min_d = 16'd66;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset ray has zero direction: all degenerate
        push_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_tri(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        push_tri(32'hFFFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 1, 32'hFFFFFFFF,
                 32'h80000000, 32'h7FFFFFFF, 32'h55555555);
        wait_idle();

        // ray along +z from the origin; distance equals plane z in raw units
        set_ray(0, 0, 0, 0, 0, 32'h10000, 100);
        z = 32'h30000;
        push_tri(-32'h10000, -32'h10000, z, 32'h30000, -32'h10000, z, -32'h10000, 32'h30000, z);
        push_tri(-32'h10000, -32'h10000, z, -32'h10000, 32'h30000, z, 32'h30000, -32'h10000, z);
        push_tri(0, 0, z, 32'h10000, 0, z, 0, 32'h10000, z);
        push_tri(-32'h10000, 0, z, 32'h10000, 0, z, 0, 32'h10000, z);
        push_tri(-32'h10000, -32'h10000, z, 32'h10000, -32'h10000, z, -32'h10000, 32'h10000, z);
        push_tri(32'h10, 32'h10, z, 32'h10000, 32'h10, z, 32'h10, 32'h10000, z);
        push_tri(5, 5, z, 5, 5, z, 5, 5, z);
        push_tri(-32'h10000, -32'h10000, 100, 32'h30000, -32'h10000, 100,
                 -32'h10000, 32'h30000, 100);
        push_tri(-32'h10000, -32'h10000, 99, 32'h30000, -32'h10000, 99,
                 -32'h10000, 32'h30000, 99);
        push_tri(-32'h10000, -32'h10000, -z, 32'h30000, -32'h10000, -z,
                 -32'h10000, 32'h30000, -z);
        push_tri(-32'h10000, -32'h10000, 32'h7FFFFFFF, 32'h30000, -32'h10000, 32'h7FFFFFFF,
                 -32'h10000, 32'h30000, 32'h7FFFFFFF);
        wait_idle();

        // tiny direction: the far triangle saturates, the nearer ones do not
        set_ray(0, 0, 0, 0, 0, 1, 0);
        push_tri(-32'h10000, -32'h10000, 32'h10000, 32'h30000, -32'h10000, 32'h10000,
                 -32'h10000, 32'h30000, 32'h10000);
        push_tri(-32'h10000, -32'h10000, 0, 32'h30000, -32'h10000, 0,
                 -32'h10000, 32'h30000, 0);
        push_tri(-32'h10000, -32'h10000, 1, 32'h30000, -32'h10000, 1,
                 -32'h10000, 32'h30000, 1);
        wait_idle();

        // extreme registers, unused index written too
        cfg_write(REG_UNUSED, 32'hFFFFFFFF);
        set_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
        for (int i = 0; i < 6; i++) push_noise();
        push_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            no_idle = (ph == 3);
            if (ph == 6)
                set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                set_ray(srand(1 << 20), srand(1 << 20), srand(1 << 20),
                        srand(1 << 17), srand(1 << 17), srand(1 << 17),
                        ph == 1 ? 0 : ph == 2 ? 16'hFFFF : $urandom_range(0, 16'hFFFF));
            for (int i = 0; i < 230; i++) begin
                if (ph == 6 || $urandom_range(0, 99) < 20) push_noise();
                else push_aimed();
            end
            if (ph == 2) out_hold = 400;
            wait_idle();
        end

        if (n_fail == 0) begin
            $display("ray_triangle_intersect: match");
        end else begin
            $display("ray_triangle_intersect: mismatch");
        end
        $finish;
    end

endmodule

/* ray_triangle_intersect.f */
rtl/rti_pkg.sv
rtl/ray_triangle_intersect.sv
rtl/rti_checker.sv
dv/ray_triangle_intersect_tb.sv
